// ----- sv/cpuv_pkg.sv -----
// ----------------------------------------------------------------------------
// cpuv_pkg
// Shared types, widths and state codes for the consecutive point unit vector
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpuv_pkg;

    // fraction bits of the unit vector components
    localparam int UNIT_FRAC_BITS = 14;

    // field widths
    localparam int COORD_W = 20;
    localparam int UNIT_W  = 16;

    // datapath widths
    localparam int DIFF_W  = COORD_W + 1;         // signed difference
    localparam int MAG_W   = COORD_W;             // |difference|
    localparam int SQ_W    = 2 * MAG_W;           // squared magnitude
    localparam int SUM_W   = SQ_W + 2;            // squared length
    localparam int DREM_W  = SUM_W + 1;           // divider remainder
    localparam int QUO_W   = 2 * UNIT_FRAC_BITS + 3;  // a^2 * 4^(U+1) / S
    localparam int ROOT_STEPS = (QUO_W + 1) / 2;  // two radicand bits a step
    localparam int RSRC_W  = 2 * ROOT_STEPS;
    localparam int ROOT_W  = ROOT_STEPS + 1;
    localparam int RREM_W  = ROOT_W + 1;
    localparam int RCUR_W  = RREM_W + 2;
    localparam int CNT_W   = $clog2(QUO_W);

    // job queue between front and back
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    // input item
    typedef struct packed {
        logic                      chain_start;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } point_t;

    // result item
    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic                     degenerate;
    } result_t;

    // classified work handed from front to back
    typedef struct packed {
        logic                     degenerate;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
    } job_t;

    // per-lane operation strobes
    typedef struct packed {
        logic load;
        logic square;
        logic div_init;
        logic div_step;
        logic root_init;
        logic root_step;
        logic round;
    } lane_ctrl_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_SUM,
        BK_DIVIDE,
        BK_RINIT,
        BK_ROOT,
        BK_ROUND,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ----- sv/cpuv_front.sv -----
// ----------------------------------------------------------------------------
// cpuv_front
// Takes points, keeps the previous point of the chain and queues the
// difference vector for every point that follows one.
// ----------------------------------------------------------------------------
`default_nettype none

module cpuv_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire cpuv_pkg::point_t point,
    output logic                 job_push,
    output cpuv_pkg::job_t       job,
    input  wire logic            job_full
);
    import cpuv_pkg::*;

    logic                      accept;
    logic                      have_prev_reg;
    logic                      have_prev_next;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic signed [COORD_W-1:0] prev_z_reg;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DIFF_W-1:0]  dz;

    // handshake
    assign full   = job_full;
    assign accept = push && !job_full;

    // difference to the previous point
    assign dx = DIFF_W'(point.coord_x) - DIFF_W'(prev_x_reg);
    assign dy = DIFF_W'(point.coord_y) - DIFF_W'(prev_y_reg);
    assign dz = DIFF_W'(point.coord_z) - DIFF_W'(prev_z_reg);

    // classify: chain start or no previous point gives no job
    always_comb
    begin
        job_push       = accept && !point.chain_start && have_prev_reg;
        job.dx         = dx;
        job.dy         = dy;
        job.dz         = dz;
        job.degenerate = (dx == '0) && (dy == '0) && (dz == '0);
        have_prev_next = have_prev_reg || accept;
    end

    // previous point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            if (accept)
            begin
                prev_x_reg <= point.coord_x;
                prev_y_reg <= point.coord_y;
                prev_z_reg <= point.coord_z;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/cpuv_jobq.sv -----
// ----------------------------------------------------------------------------
// cpuv_jobq
// Short queue of difference jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cpuv_jobq
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire cpuv_pkg::job_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output cpuv_pkg::job_t     rd_data,
    output logic               valid
);
    import cpuv_pkg::*;

    job_t                  mem_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_ptr_reg;
    logic [JOBQ_PTR_W-1:0] wr_ptr_next;
    logic [JOBQ_PTR_W-1:0] rd_ptr_reg;
    logic [JOBQ_PTR_W-1:0] rd_ptr_next;
    logic [JOBQ_CNT_W-1:0] cnt_reg;
    logic [JOBQ_CNT_W-1:0] cnt_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (cnt_reg == JOBQ_CNT_W'(JOBQ_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cpuv_lane.sv -----
// ----------------------------------------------------------------------------
// cpuv_lane
// One vector component: square, restoring division a^2 * 4^(U+1) / S,
// digit-by-digit integer square root and final rounding halving.
// ----------------------------------------------------------------------------
`default_nettype none

module cpuv_lane
(
    input  wire logic                                clk,
    input  wire cpuv_pkg::lane_ctrl_t                ctrl,
    input  wire logic signed [cpuv_pkg::DIFF_W-1:0]  diff,
    input  wire logic [cpuv_pkg::SUM_W-1:0]          sum_sq,
    output logic [cpuv_pkg::SQ_W-1:0]                sq,
    output logic signed [cpuv_pkg::UNIT_W-1:0]       unit
);
    import cpuv_pkg::*;

    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [DREM_W-1:0]        drem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [RSRC_W-1:0]        rsrc_reg;
    logic [RREM_W-1:0]        rrem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic signed [UNIT_W-1:0] unit_reg;

    logic signed [DIFF_W-1:0] neg_diff;
    logic [DREM_W-1:0]        div_sub;
    logic                     div_ge;
    logic [RCUR_W-1:0]        root_cur;
    logic [RCUR_W-1:0]        root_trial;
    logic [RCUR_W-1:0]        root_sub;
    logic                     root_ge;
    logic [ROOT_W:0]          root_inc;
    logic [ROOT_W-1:0]        half_mag;

    assign sq   = sq_reg;
    assign unit = unit_reg;

    // magnitude of the incoming difference
    assign neg_diff = -diff;

    // one restoring division step
    always_comb
    begin
        div_ge  = (drem_reg >= DREM_W'(sum_sq));
        div_sub = div_ge ? (drem_reg - DREM_W'(sum_sq)) : drem_reg;
    end

    // one square root step, two radicand bits at a time
    always_comb
    begin
        root_cur   = {rrem_reg, rsrc_reg[RSRC_W-1 -: 2]};
        root_trial = RCUR_W'({root_reg, 2'b01});
        root_ge    = (root_cur >= root_trial);
        root_sub   = root_ge ? (root_cur - root_trial) : root_cur;
    end

    // round to nearest: m = (t + 1) / 2
    always_comb
    begin
        root_inc = {1'b0, root_reg} + 1'b1;
        half_mag = root_inc[ROOT_W:1];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            neg_reg <= diff[DIFF_W-1];
            mag_reg <= diff[DIFF_W-1] ? MAG_W'(neg_diff) : MAG_W'(diff);
        end
        if (ctrl.square)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
        if (ctrl.div_init)
        begin
            drem_reg <= DREM_W'(sq_reg);
            quo_reg  <= '0;
        end
        else if (ctrl.div_step)
        begin
            drem_reg <= {div_sub[DREM_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[QUO_W-2:0], div_ge};
        end
        if (ctrl.root_init)
        begin
            rsrc_reg <= RSRC_W'(quo_reg);
            rrem_reg <= '0;
            root_reg <= '0;
        end
        else if (ctrl.root_step)
        begin
            rsrc_reg <= {rsrc_reg[RSRC_W-3:0], 2'b00};
            rrem_reg <= root_sub[RREM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], root_ge};
        end
        if (ctrl.round)
        begin
            unit_reg <= neg_reg ? -UNIT_W'(half_mag) : UNIT_W'(half_mag);
        end
    end

endmodule

`default_nettype wire

// ----- sv/cpuv_back.sv -----
// ----------------------------------------------------------------------------
// cpuv_back
// Sequencer over three component lanes and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpuv_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    input  wire cpuv_pkg::job_t    job,
    output logic                   job_pop,
    output logic                   empty,
    input  wire logic              pop,
    output cpuv_pkg::result_t      result
);
    import cpuv_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             deg_reg;
    logic             deg_next;
    logic [SUM_W-1:0] sum_reg;
    logic             sum_load;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    logic             out_load;
    logic             out_free;
    lane_ctrl_t       ctrl;

    logic [SQ_W-1:0]          sq_x;
    logic [SQ_W-1:0]          sq_y;
    logic [SQ_W-1:0]          sq_z;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // component lanes
    cpuv_lane u_lane_x
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .diff   (job.dx),
        .sum_sq (sum_reg),
        .sq     (sq_x),
        .unit   (unit_x)
    );

    cpuv_lane u_lane_y
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .diff   (job.dy),
        .sum_sq (sum_reg),
        .sq     (sq_y),
        .unit   (unit_y)
    );

    cpuv_lane u_lane_z
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .diff   (job.dz),
        .sum_sq (sum_reg),
        .sq     (sq_z),
        .unit   (unit_z)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.degenerate ? BK_DONE : BK_SQUARE;
                end
            end
            BK_SQUARE: state_next = BK_SUM;
            BK_SUM:    state_next = BK_DIVIDE;
            BK_DIVIDE:
            begin
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    state_next = BK_RINIT;
                end
            end
            BK_RINIT:  state_next = BK_ROOT;
            BK_ROOT:
            begin
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = BK_ROUND;
                end
            end
            BK_ROUND:  state_next = BK_DONE;
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl     = '0;
        job_pop  = 1'b0;
        sum_load = 1'b0;
        out_load = 1'b0;
        cnt_next = cnt_reg;
        deg_next = deg_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    ctrl.load = 1'b1;
                    deg_next  = job.degenerate;
                end
            end
            BK_SQUARE:
            begin
                ctrl.square = 1'b1;
            end
            BK_SUM:
            begin
                sum_load      = 1'b1;
                ctrl.div_init = 1'b1;
                cnt_next      = '0;
            end
            BK_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
            end
            BK_RINIT:
            begin
                ctrl.root_init = 1'b1;
                cnt_next       = '0;
            end
            BK_ROOT:
            begin
                ctrl.root_step = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
            end
            BK_ROUND:
            begin
                ctrl.round = 1'b1;
            end
            BK_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            deg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            deg_reg       <= deg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // squared length and result payload
    always_ff @(posedge clk)
    begin
        if (sum_load)
        begin
            sum_reg <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
        end
        if (out_load)
        begin
            out_reg.degenerate <= deg_reg;
            out_reg.unit_x     <= deg_reg ? '0 : unit_x;
            out_reg.unit_y     <= deg_reg ? '0 : unit_y;
            out_reg.unit_z     <= deg_reg ? '0 : unit_z;
        end
    end

endmodule

`default_nettype wire

// ----- sv/consecutive_point_unit_vector.sv -----
// ----------------------------------------------------------------------------
// consecutive_point_unit_vector
// Unit vector between consecutive 3D points of a chain, 14 fraction bits.
//
//   channel  handshake         payload
//   point    push / full       chain_start, coord_x, coord_y, coord_z
//   result   empty / pop       unit_x, unit_y, unit_z, degenerate
//
// A point that follows another passes the 31-step divider and 16-step square
// root in three lanes side by side; coinciding points skip both. The back
// takes no new job until the last one's result is in the result register.
// Chain starts cause no result and are taken at one a cycle unless full.
// The front keeps taking points while the back works, until its two-entry
// job queue is full; a waiting result holds the back in its final state.
// Reset clears the previous point and the queue and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module consecutive_point_unit_vector
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire cpuv_pkg::point_t  point,
    output logic                   empty,
    input  wire logic              pop,
    output cpuv_pkg::result_t      result
);
    import cpuv_pkg::*;

    logic job_push;
    logic job_full;
    logic job_valid;
    logic job_pop;
    job_t job_in;
    job_t job_out;

    // point intake and classification
    cpuv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .point    (point),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    // decoupling queue
    cpuv_jobq u_jobq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .valid   (job_valid)
    );

    // normalisation
    cpuv_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
